// ===== hw/rtl/mts_pkg.sv =====
`default_nettype none
package mts_pkg;

  typedef logic [31:0] word_t;
  typedef logic [24:0] count_t;
  typedef logic [3:0]  phase_t;
  typedef logic [6:0]  pct_t;
  typedef logic [12:0] pct_acc_t;

  localparam phase_t PH_IDLE        = 4'd0;
  localparam phase_t PH_FILL_ADDR   = 4'd1;
  localparam phase_t PH_VERIFY_ADDR = 4'd2;
  localparam phase_t PH_FILL_A      = 4'd3;
  localparam phase_t PH_VERIFY_A    = 4'd4;
  localparam phase_t PH_FILL_B      = 4'd5;
  localparam phase_t PH_VERIFY_B    = 4'd6;
  localparam phase_t PH_DONE        = 4'd7;
  localparam phase_t PH_FAIL        = 4'd8;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_WORD_COUNT   = 1'b1;

  localparam word_t PAT_A = 32'h5555_5555;
  localparam word_t PAT_B = 32'hAAAA_AAAA;

  localparam int unsigned PCT_SCALE   = 1000;
  localparam int unsigned PCT_FULL    = 100;
  localparam int unsigned DIV_BITS    = 10;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_BITS);
  localparam int unsigned NUM_W       = 35;
  localparam int unsigned RECIP_60    = 17477;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned PROD_W      = 28;

  typedef logic [DIV_BITS-1:0]  quo_t;
  typedef logic [DIV_CNT_W-1:0] div_cnt_t;
  typedef logic [NUM_W-1:0]     num_t;
  typedef logic [PROD_W-1:0]    prod_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_NO_DIV,
    COND_DIV_LAST,
    COND_OUT_FREE
  } ucond_t;

  typedef logic [2:0] upc_t;

  localparam upc_t UA_FETCH  = 3'd0;
  localparam upc_t UA_SETUP  = 3'd1;
  localparam upc_t UA_DIVIDE = 3'd2;
  localparam upc_t UA_SCALE  = 3'd3;
  localparam upc_t UA_EMIT   = 3'd4;

  typedef struct packed {
    logic   take_item;
    logic   div_load;
    logic   div_step;
    logic   scale;
    logic   emit;
    ucond_t cond;
    logic   hold;
    upc_t   target;
  } uword_t;

  function automatic uword_t ucode_rom(upc_t addr);
    uword_t w;
    w = '{take_item: 1'b0, div_load: 1'b0, div_step: 1'b0, scale: 1'b0, emit: 1'b0,
          cond: COND_ALWAYS, hold: 1'b0, target: UA_FETCH};
    case (addr)
      UA_FETCH: begin
        w.take_item = 1'b1;
        w.cond      = COND_IN_VALID;
        w.hold      = 1'b1;
        w.target    = UA_SETUP;
      end
      UA_SETUP: begin
        w.div_load = 1'b1;
        w.cond     = COND_NO_DIV;
        w.target   = UA_EMIT;
      end
      UA_DIVIDE: begin
        w.div_step = 1'b1;
        w.cond     = COND_DIV_LAST;
        w.hold     = 1'b1;
        w.target   = UA_SCALE;
      end
      UA_SCALE: begin
        w.scale  = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = UA_EMIT;
      end
      UA_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_FREE;
        w.hold   = 1'b1;
        w.target = UA_FETCH;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = UA_FETCH;
      end
    endcase
    return w;
  endfunction

  function automatic pct_acc_t phase_base(phase_t ph);
    pct_acc_t b;
    case (ph)
      PH_FILL_ADDR:   b = 13'd0;
      PH_VERIFY_ADDR: b = 13'd1000;
      PH_FILL_A:      b = 13'd2000;
      PH_VERIFY_A:    b = 13'd3000;
      PH_FILL_B:      b = 13'd4000;
      PH_VERIFY_B:    b = 13'd5000;
      default:        b = 13'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mts_in_if.sv =====
`default_nettype none
interface mts_in_if
  import mts_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  opcode;
  word_t read_data;

  modport source (output valid, output opcode, output read_data, input ready);
  modport sink   (input valid, input opcode, input read_data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mts_out_if.sv =====
`default_nettype none
interface mts_out_if
  import mts_pkg::*;
();
  logic   valid;
  logic   ready;
  phase_t phase;
  logic   write_enable;
  word_t  write_address;
  word_t  write_data;
  word_t  next_address;
  logic   next_is_verify;
  word_t  fail_address;
  word_t  fail_got;
  word_t  fail_expected;
  pct_t   progress_percent;

  modport source (
    output valid, output phase, output write_enable, output write_address,
    output write_data, output next_address, output next_is_verify,
    output fail_address, output fail_got, output fail_expected,
    output progress_percent, input ready
  );
  modport sink (
    input valid, input phase, input write_enable, input write_address,
    input write_data, input next_address, input next_is_verify,
    input fail_address, input fail_got, input fail_expected,
    input progress_percent, output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/memory_test_sequencer_core.sv =====
// Microcode steps per item: fetch (holds until an item is valid), setup, then, when a
// progress division is needed, 10 steps of the bit-serial progress divider and scale;
// otherwise setup jumps straight to emit. Emit holds until the output is free.
// A new item is taken only after the last result is emitted, even while that result waits.
// Reset (synchronous, rst_n low): phase idle, position and captured failure cleared,
// base address and word count zero, microcode back at fetch, no result pending.
`default_nettype none
module memory_test_sequencer_core
  import mts_pkg::*;
#(
  parameter int unsigned MAX_WORDS = 16777216
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [31:0] cfg_wdata,
  mts_in_if.sink     in_item,
  mts_out_if.source  out_item
);

  word_t    base_r;
  count_t   count_r;
  phase_t   phase_r;
  count_t   pos_r;
  word_t    fail_addr_r;
  word_t    fail_got_r;
  word_t    fail_exp_r;
  logic     wr_en_r;
  word_t    wr_addr_r;
  word_t    wr_data_r;
  upc_t     upc_r;
  num_t     rem_r;
  num_t     den_r;
  quo_t     quo_r;
  div_cnt_t cnt_r;
  prod_t    prod_r;

  logic     out_valid_r;
  phase_t   out_phase_r;
  logic     out_we_r;
  word_t    out_wa_r;
  word_t    out_wd_r;
  word_t    out_next_r;
  logic     out_verify_r;
  word_t    out_fa_r;
  word_t    out_fg_r;
  word_t    out_fe_r;
  pct_t     out_pct_r;

  phase_t   phase_nxt;
  count_t   pos_nxt;
  word_t    fail_addr_nxt;
  word_t    fail_got_nxt;
  word_t    fail_exp_nxt;
  logic     wr_en_nxt;
  word_t    wr_addr_nxt;
  word_t    wr_data_nxt;
  upc_t     upc_nxt;

  uword_t   uw;
  logic     jump;
  logic     busy;
  logic     no_div;
  logic     last_word;
  logic     fire;
  count_t   n_eff;
  count_t   pos_clamp;
  logic [25:0] pos_inc;
  word_t    addr_cur;
  word_t    exp_cur;
  num_t     num;
  pct_acc_t pct_acc;
  pct_t     pct;

  assign uw   = ucode_rom(upc_r);
  assign fire = uw.take_item && in_item.valid;

  assign busy  = (phase_r >= PH_FILL_ADDR) && (phase_r <= PH_VERIFY_B);
  assign n_eff = ({6'b0, count_r} > 31'(MAX_WORDS)) ? 25'(MAX_WORDS) : count_r;
  assign no_div = !busy || (n_eff == '0);

  assign addr_cur  = {base_r[31:2], 2'b00} + {5'b0, pos_r, 2'b00};
  assign pos_inc   = {1'b0, pos_r} + 26'd1;
  assign last_word = pos_inc >= {1'b0, n_eff};

  always_comb begin
    if (phase_r <= PH_VERIFY_ADDR) begin
      exp_cur = addr_cur;
    end else if (phase_r <= PH_VERIFY_A) begin
      exp_cur = PAT_A;
    end else begin
      exp_cur = PAT_B;
    end
  end

  assign pos_clamp = (pos_r > n_eff) ? n_eff : pos_r;
  assign num       = NUM_W'(pos_clamp) * NUM_W'(PCT_SCALE);
  assign pct_acc   = phase_base(phase_r) + pct_acc_t'(quo_r);

  always_comb begin
    if (phase_r == PH_IDLE) begin
      pct = '0;
    end else if (!busy) begin
      pct = 7'(PCT_FULL);
    end else if (n_eff == '0) begin
      pct = '0;
    end else begin
      pct = prod_r[RECIP_SHIFT +: 7];
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    fail_addr_nxt = fail_addr_r;
    fail_got_nxt  = fail_got_r;
    fail_exp_nxt  = fail_exp_r;
    wr_en_nxt     = 1'b0;
    wr_addr_nxt   = '0;
    wr_data_nxt   = '0;
    if (in_item.opcode == OP_START) begin
      if (!busy) begin
        pos_nxt       = '0;
        fail_addr_nxt = '0;
        fail_got_nxt  = '0;
        fail_exp_nxt  = '0;
        phase_nxt     = (count_r == '0) ? PH_FAIL : PH_FILL_ADDR;
      end
    end else if (busy) begin
      if (phase_r[0]) begin
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = addr_cur;
        wr_data_nxt = exp_cur;
      end
      if (!phase_r[0] && (in_item.read_data != exp_cur)) begin
        fail_addr_nxt = addr_cur;
        fail_got_nxt  = in_item.read_data;
        fail_exp_nxt  = exp_cur;
        phase_nxt     = PH_FAIL;
      end else if (last_word) begin
        pos_nxt   = '0;
        phase_nxt = phase_r + 4'd1;
      end else begin
        pos_nxt = pos_inc[24:0];
      end
    end
  end

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:   jump = 1'b1;
      COND_IN_VALID: jump = in_item.valid;
      COND_NO_DIV:   jump = no_div;
      COND_DIV_LAST: jump = (cnt_r == '0);
      COND_OUT_FREE: jump = !out_valid_r || out_item.ready;
      default:       jump = 1'b0;
    endcase
    if (jump) begin
      upc_nxt = uw.target;
    end else if (uw.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      count_r     <= '0;
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      fail_addr_r <= '0;
      fail_got_r  <= '0;
      fail_exp_r  <= '0;
      upc_r       <= UA_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_ADDRESS: base_r  <= cfg_wdata;
          CFG_WORD_COUNT:   count_r <= cfg_wdata[24:0];
          default:          base_r  <= base_r;
        endcase
      end
      if (fire) begin
        phase_r     <= phase_nxt;
        pos_r       <= pos_nxt;
        fail_addr_r <= fail_addr_nxt;
        fail_got_r  <= fail_got_nxt;
        fail_exp_r  <= fail_exp_nxt;
      end
      if (uw.emit && (!out_valid_r || out_item.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      wr_en_r   <= wr_en_nxt;
      wr_addr_r <= wr_addr_nxt;
      wr_data_r <= wr_data_nxt;
    end
    if (uw.div_load) begin
      rem_r <= num;
      den_r <= NUM_W'(n_eff) << (DIV_BITS - 1);
      quo_r <= '0;
      cnt_r <= DIV_CNT_W'(DIV_BITS - 1);
    end else if (uw.div_step) begin
      if (rem_r >= den_r) begin
        rem_r <= rem_r - den_r;
        quo_r <= {quo_r[DIV_BITS-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[DIV_BITS-2:0], 1'b0};
      end
      den_r <= den_r >> 1;
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
    if (uw.scale) begin
      prod_r <= PROD_W'(pct_acc) * PROD_W'(RECIP_60);
    end
    if (uw.emit && (!out_valid_r || out_item.ready)) begin
      out_phase_r  <= phase_r;
      out_we_r     <= wr_en_r;
      out_wa_r     <= wr_addr_r;
      out_wd_r     <= wr_data_r;
      out_next_r   <= busy ? addr_cur : '0;
      out_verify_r <= busy && !phase_r[0];
      out_fa_r     <= fail_addr_r;
      out_fg_r     <= fail_got_r;
      out_fe_r     <= fail_exp_r;
      out_pct_r    <= pct;
    end
  end

  assign in_item.ready            = uw.take_item;
  assign out_item.valid           = out_valid_r;
  assign out_item.phase           = out_phase_r;
  assign out_item.write_enable    = out_we_r;
  assign out_item.write_address   = out_wa_r;
  assign out_item.write_data      = out_wd_r;
  assign out_item.next_address    = out_next_r;
  assign out_item.next_is_verify  = out_verify_r;
  assign out_item.fail_address    = out_fa_r;
  assign out_item.fail_got        = out_fg_r;
  assign out_item.fail_expected   = out_fe_r;
  assign out_item.progress_percent = out_pct_r;

endmodule
`default_nettype wire
